/* rtl/srle_pkg.sv */
// ----------------------------------------------------------------------------
// srle_pkg
// Shared types and constants of the scanline RLE sprite decoder.
// ----------------------------------------------------------------------------
package srle_pkg;

  typedef enum logic [25:0] {
    PH_TAG      = 26'd1 << 0,
    PH_LEN_LO   = 26'd1 << 1,
    PH_LEN_HI   = 26'd1 << 2,
    PH_UN1      = 26'd1 << 3,
    PH_UN2      = 26'd1 << 4,
    PH_YA_LO    = 26'd1 << 5,
    PH_YA_HI    = 26'd1 << 6,
    PH_NL_LO    = 26'd1 << 7,
    PH_NL_HI    = 26'd1 << 8,
    PH_OP       = 26'd1 << 9,
    PH_PAD7A    = 26'd1 << 10,
    PH_PAD7B    = 26'd1 << 11,
    PH_PAD8A    = 26'd1 << 12,
    PH_PAD8B    = 26'd1 << 13,
    PH_COPY     = 26'd1 << 14,
    PH_RLE_CNT  = 26'd1 << 15,
    PH_RLE_LIT  = 26'd1 << 16,
    PH_RLE_FILL = 26'd1 << 17,
    PH_SKP_CNT  = 26'd1 << 18,
    PH_SKP_LIT  = 26'd1 << 19,
    PH_OFS_LEAD = 26'd1 << 20,
    PH_OFS_CNT  = 26'd1 << 21,
    PH_OFS_LIT  = 26'd1 << 22,
    PH_OFS_FILL = 26'd1 << 23,
    PH_OFS_GAP  = 26'd1 << 24,
    PH_DONE     = 26'd1 << 25
  } phase_t;

  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_OVERRUN  = 3'd2;
  localparam logic [2:0] ST_BAD_OP   = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;
  localparam logic [2:0] ST_BAD_TAG  = 3'd5;

  localparam logic [7:0] OP_COPY     = 8'd0;
  localparam logic [7:0] OP_RLE      = 8'd1;
  localparam logic [7:0] OP_SKIP     = 8'd2;
  localparam logic [7:0] OP_OFFSET   = 8'd3;
  localparam logic [7:0] OP_EMPTY    = 8'd4;
  localparam logic [7:0] OP_SKIP_PAD = 8'd7;
  localparam logic [7:0] OP_OFS_PAD  = 8'd8;

  localparam logic [7:0] TAG_DONE_A  = 8'h03;
  localparam logic [7:0] TAG_DONE_B  = 8'h20;
  localparam logic [7:0] TAG_UNSUPP  = 8'h04;
  localparam logic [7:0] GAP_EOL     = 8'hFF;

  localparam int CFG_ORIGIN_X = 0;
  localparam int CFG_ORIGIN_Y = 1;

  typedef struct packed {
    logic        have;
    logic        wvalid;
    logic [18:0] addr;
    logic [6:0]  len;
    logic [7:0]  value;
    logic [2:0]  status;
  } result_t;

endpackage

/* rtl/srle_clip.sv */
// ----------------------------------------------------------------------------
// srle_clip
// Clips one pixel run at the cursor to the linear surface.
// ----------------------------------------------------------------------------
module srle_clip #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic [31:0] cursor,
  input  logic [7:0]  run_len,
  output logic        hit,
  output logic [18:0] addr,
  output logic [6:0]  len
);

  localparam logic signed [33:0] SURF = 34'(SCREEN_WIDTH * SCREEN_HEIGHT);

  logic signed [33:0] s_pos;
  logic signed [33:0] e_pos;
  logic signed [33:0] lo;
  logic signed [33:0] hi;
  logic signed [33:0] diff;

  always_comb begin
    s_pos = $signed({{2{cursor[31]}}, cursor});
    e_pos = s_pos + $signed({26'd0, run_len});
    lo    = (s_pos < 0) ? 34'sd0 : s_pos;
    hi    = (e_pos > SURF) ? SURF : e_pos;
    diff  = hi - lo;
    hit   = hi > lo;
    addr  = hit ? lo[18:0] : 19'd0;
    len   = hit ? diff[6:0] : 7'd0;
  end

endmodule

/* rtl/srle_dec.sv */
// ----------------------------------------------------------------------------
// srle_dec
// Parser state and per-byte next-state logic of the sprite decoder.
// ----------------------------------------------------------------------------
module srle_dec import srle_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [31:0] origin_base,
  output result_t     res
);

  localparam logic signed [33:0] SURF = 34'(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam logic [31:0] WIDTH32 = 32'(SCREEN_WIDTH);

  phase_t      phase_r, phase_nxt;
  logic [31:0] line_r, line_nxt;
  logic [31:0] cursor_r, cursor_nxt;
  logic [15:0] lit_r, lit_nxt;
  logic [15:0] lines_r, lines_nxt;
  logic [15:0] copy_r, copy_nxt;
  logic [7:0]  run_r, run_nxt;
  logic [7:0]  hold_r, hold_nxt;

  logic        rw_en;
  logic [7:0]  rw_len;
  logic        clip_hit;
  logic [18:0] clip_addr;
  logic [6:0]  clip_len;
  logic        do_ld;
  logic        fin;
  logic [2:0]  fin_st;
  logic [31:0] ld_line;
  logic [15:0] ld_lines;
  logic        ld_end;
  logic [15:0] word16;
  logic signed [29:0] ya_prod;
  logic [31:0] end_line;
  logic [7:0]  neg_c;

  srle_clip #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_clip (
    .cursor (cursor_r),
    .run_len(rw_len),
    .hit    (clip_hit),
    .addr   (clip_addr),
    .len    (clip_len)
  );

  assign word16   = {data_byte, hold_r};
  assign ya_prod  = $signed(word16) * $signed(14'(SCREEN_WIDTH));
  assign ld_line  = line_r + WIDTH32;
  assign ld_lines = lines_r - 16'd1;
  assign ld_end   = $signed({{2{ld_line[31]}}, ld_line}) >= SURF;
  assign neg_c    = 8'd0 - data_byte;

  always_comb begin
    phase_nxt  = phase_r;
    line_nxt   = line_r;
    cursor_nxt = cursor_r;
    lit_nxt    = lit_r;
    lines_nxt  = lines_r;
    copy_nxt   = copy_r;
    run_nxt    = run_r;
    hold_nxt   = hold_r;
    rw_en      = 1'b0;
    rw_len     = 8'd0;
    do_ld      = 1'b0;
    fin        = 1'b0;
    fin_st     = ST_BUSY;
    end_line   = 32'd0;
    case (phase_r)
      PH_TAG: begin
        if (data_byte == TAG_DONE_A || data_byte == TAG_DONE_B) begin
          fin    = 1'b1;
          fin_st = ST_DONE;
        end else if (data_byte == TAG_UNSUPP) begin
          fin    = 1'b1;
          fin_st = ST_BAD_TAG;
        end else begin
          line_nxt  = origin_base;
          phase_nxt = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        hold_nxt  = data_byte;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        lit_nxt   = word16;
        phase_nxt = PH_UN1;
      end
      PH_UN1: phase_nxt = PH_UN2;
      PH_UN2: phase_nxt = PH_YA_LO;
      PH_YA_LO: begin
        hold_nxt  = data_byte;
        phase_nxt = PH_YA_HI;
      end
      PH_YA_HI: begin
        line_nxt  = line_r + {{2{ya_prod[29]}}, ya_prod};
        phase_nxt = PH_NL_LO;
      end
      PH_NL_LO: begin
        hold_nxt  = data_byte;
        phase_nxt = PH_NL_HI;
      end
      PH_NL_HI: begin
        if (word16 == 16'd0) begin
          fin    = 1'b1;
          fin_st = ST_DONE;
        end else if (word16[15]) begin
          phase_nxt = PH_YA_LO;
        end else begin
          lines_nxt = word16;
          phase_nxt = PH_OP;
        end
      end
      PH_OP: begin
        cursor_nxt = line_r;
        case (data_byte)
          OP_COPY: begin
            if (lit_r[15] || lit_r == 16'd0) begin
              do_ld = 1'b1;
            end else begin
              copy_nxt  = lit_r;
              phase_nxt = PH_COPY;
            end
          end
          OP_RLE:      phase_nxt = PH_RLE_CNT;
          OP_SKIP:     phase_nxt = PH_SKP_CNT;
          OP_OFFSET:   phase_nxt = PH_OFS_LEAD;
          OP_EMPTY:    do_ld = 1'b1;
          OP_SKIP_PAD: phase_nxt = PH_PAD7A;
          OP_OFS_PAD:  phase_nxt = PH_PAD8A;
          default: begin
            fin    = 1'b1;
            fin_st = ST_BAD_OP;
          end
        endcase
      end
      PH_PAD7A: phase_nxt = PH_PAD7B;
      PH_PAD7B: phase_nxt = PH_SKP_CNT;
      PH_PAD8A: phase_nxt = PH_PAD8B;
      PH_PAD8B: phase_nxt = PH_OFS_LEAD;
      PH_COPY: begin
        rw_en    = 1'b1;
        rw_len   = 8'd1;
        copy_nxt = copy_r - 16'd1;
        if (copy_r == 16'd1) begin
          do_ld = 1'b1;
        end
      end
      PH_RLE_CNT: begin
        if (data_byte == 8'd0) begin
          do_ld = 1'b1;
        end else if (data_byte[7]) begin
          run_nxt   = neg_c;
          phase_nxt = PH_RLE_LIT;
        end else begin
          run_nxt   = data_byte;
          phase_nxt = PH_RLE_FILL;
        end
      end
      PH_RLE_LIT: begin
        rw_en   = 1'b1;
        rw_len  = 8'd1;
        run_nxt = run_r - 8'd1;
        if (run_r == 8'd1) begin
          phase_nxt = PH_RLE_CNT;
        end
      end
      PH_RLE_FILL: begin
        rw_en     = 1'b1;
        rw_len    = run_r;
        phase_nxt = PH_RLE_CNT;
      end
      PH_SKP_CNT: begin
        if (data_byte == 8'd0) begin
          do_ld = 1'b1;
        end else if (data_byte[7]) begin
          run_nxt   = neg_c;
          phase_nxt = PH_SKP_LIT;
        end else begin
          cursor_nxt = cursor_r + {24'd0, data_byte};
        end
      end
      PH_SKP_LIT: begin
        rw_en   = 1'b1;
        rw_len  = 8'd1;
        run_nxt = run_r - 8'd1;
        if (run_r == 8'd1) begin
          phase_nxt = PH_SKP_CNT;
        end
      end
      PH_OFS_LEAD: begin
        cursor_nxt = cursor_r + {24'd0, data_byte};
        phase_nxt  = PH_OFS_CNT;
      end
      PH_OFS_CNT: begin
        if (data_byte == 8'd0) begin
          phase_nxt = PH_OFS_GAP;
        end else if (data_byte[7]) begin
          run_nxt   = neg_c;
          phase_nxt = PH_OFS_LIT;
        end else begin
          run_nxt   = data_byte;
          phase_nxt = PH_OFS_FILL;
        end
      end
      PH_OFS_LIT: begin
        rw_en   = 1'b1;
        rw_len  = 8'd1;
        run_nxt = run_r - 8'd1;
        if (run_r == 8'd1) begin
          phase_nxt = PH_OFS_GAP;
        end
      end
      PH_OFS_FILL: begin
        rw_en     = 1'b1;
        rw_len    = run_r;
        phase_nxt = PH_OFS_GAP;
      end
      PH_OFS_GAP: begin
        if (data_byte == GAP_EOL) begin
          do_ld = 1'b1;
        end else begin
          cursor_nxt = cursor_r + {24'd0, data_byte};
          phase_nxt  = PH_OFS_CNT;
        end
      end
      default: ;
    endcase

    if (rw_en) begin
      cursor_nxt = cursor_r + {24'd0, rw_len};
    end
    if (do_ld) begin
      line_nxt  = ld_line;
      lines_nxt = ld_lines;
      if (ld_end) begin
        fin    = 1'b1;
        fin_st = ST_DONE;
      end else begin
        phase_nxt = (ld_lines == 16'd0) ? PH_YA_LO : PH_OP;
      end
    end
    if (fin) begin
      phase_nxt = PH_DONE;
    end

    if (last_byte) begin
      if (phase_nxt != PH_DONE) begin
        fin = 1'b1;
        if (phase_nxt == PH_TAG || phase_nxt == PH_LEN_LO || phase_nxt == PH_LEN_HI
            || phase_nxt == PH_UN1 || phase_nxt == PH_UN2) begin
          fin_st = ST_TRUNC;
        end else if (phase_nxt == PH_YA_LO || phase_nxt == PH_YA_HI
                     || phase_nxt == PH_NL_LO || phase_nxt == PH_NL_HI) begin
          fin_st = ST_OVERRUN;
        end else begin
          end_line = line_nxt + WIDTH32;
          fin_st = ($signed({{2{end_line[31]}}, end_line}) >= SURF) ? ST_DONE : ST_OVERRUN;
        end
      end
      phase_nxt = PH_TAG;
    end

    res.wvalid = rw_en && clip_hit;
    res.addr   = (rw_en && clip_hit) ? clip_addr : 19'd0;
    res.len    = (rw_en && clip_hit) ? clip_len : 7'd0;
    res.value  = (rw_en && clip_hit) ? data_byte : 8'd0;
    res.status = fin ? fin_st : ST_BUSY;
    res.have   = (rw_en && clip_hit) || fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG;
      line_r   <= 32'd0;
      cursor_r <= 32'd0;
      lit_r    <= 16'd0;
      lines_r  <= 16'd0;
      copy_r   <= 16'd0;
      run_r    <= 8'd0;
      hold_r   <= 8'd0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      line_r   <= line_nxt;
      cursor_r <= cursor_nxt;
      lit_r    <= lit_nxt;
      lines_r  <= lines_nxt;
      copy_r   <= copy_nxt;
      run_r    <= run_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule

/* rtl/scanline_rle_sprite_decoder.sv */
// ----------------------------------------------------------------------------
// scanline_rle_sprite_decoder
// Decodes a byte-serial scanline RLE sprite blob into clipped run writes.
// ----------------------------------------------------------------------------
// Blob bytes arrive on the in_ channel, one word per byte, with in_last_byte
// on the final byte. Each byte yields at most one word on the out_ channel:
// a clipped framebuffer run (address, length, value), an image status, or
// both. Bytes that produce nothing give no output word.
// The origin registers are written over the cfg_ channel, index 0 for the
// column and 1 for the row; the user must write them only while the block
// is idle, as the block does not enforce it. A write goes through the origin
// register and then origin_base_r before it reaches the linear address.
// A byte is registered on acceptance; its result is registered when the
// decoder advances, which out_stall can hold back. One byte is taken per
// cycle unless in_stall is high; the per-byte decoder update is the only loop.
// When out_stall holds a result, the input register keeps one further byte
// and then in_stall rises until the result is taken.
// Reset returns the parser to the tag phase, clears the origin and empties
// both registers.
// ----------------------------------------------------------------------------
module scanline_rle_sprite_decoder import srle_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_valid,
  output logic [18:0] out_write_addr,
  output logic [6:0]  out_write_len,
  output logic [7:0]  out_pixel_value,
  output logic [2:0]  out_image_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  logic [11:0] origin_x_r;
  logic [11:0] origin_y_r;
  logic [31:0] origin_base_r;
  logic signed [25:0] oy_prod;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        adv;
  result_t     res;
  result_t     out_r;
  logic        out_valid_r;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign oy_prod   = $signed(origin_y_r) * $signed(14'(SCREEN_WIDTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= 12'd0;
      origin_y_r <= 12'd0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == 2'(CFG_ORIGIN_X)) begin
        origin_x_r <= cfg_data;
      end else if (cfg_index == 2'(CFG_ORIGIN_Y)) begin
        origin_y_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    origin_base_r <= {{6{oy_prod[25]}}, oy_prod} + {{20{origin_x_r[11]}}, origin_x_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  srle_dec #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .data_byte  (s1_byte_r),
    .last_byte  (s1_last_r),
    .origin_base(origin_base_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.have;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_valid  = out_r.wvalid;
  assign out_write_addr   = out_r.addr;
  assign out_write_len    = out_r.len;
  assign out_pixel_value  = out_r.value;
  assign out_image_status = out_r.status;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled without a held byte and a held result");

  a_write_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid |-> out_write_len != 7'd0)
    else $error("run write with zero length");

  a_word_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_image_status != ST_BUSY)
    else $error("output word carries neither a write nor a status");

  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.have |=> out_valid_r)
    else $error("decoded result was not captured");
`endif

endmodule
